[src/skt_pkg.sv]
package skt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_TOUCH  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_TOUCH,
        S_DONE_OK,
        S_DONE_FULL,
        S_DONE_MISS
    } state_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       pos_end;
        logic       rd;
        logic       cmp;
        logic       set_shift;
        logic       shift_rd;
        logic       shift_wr;
        logic       write_new;
        logic       write_time;
        logic       finish;
        logic [1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_remove;
        logic is_lookup;
        logic ordered;
        logic binary;
        logic full;
        logic scan_end;
        logic lt;
        logic eq;
        logic shift_end;
    } flags_t;

endpackage

[src/session_key_table.sv]
// flow: an append insert writes at the end; a sorted insert scans linearly and
// then shifts; a remove searches (binary in ordered mode, else linear) and then
// shifts; a lookup or touch searches the same way, a touch then writes the time
// throughput: one transaction at a time; the next is taken once the result is
// presented, each table step a read then a compare or write on one port
// reset: entry count cleared, ordered_mode set, table contents undefined
module session_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [63:0] key,
    input  logic [15:0] user_handle,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [5:0]  slot,
    output logic [15:0] found_user,
    output logic [31:0] found_time,
    output logic [6:0]  entry_total
);

    cmd_t   cmd;
    flags_t flags;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    skt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mode           (mode),
        .key            (key),
        .user_handle    (user_handle),
        .now_time       (now_time),
        .cmd            (cmd),
        .flags          (flags),
        .status         (status),
        .slot           (slot),
        .found_user     (found_user),
        .found_time     (found_time),
        .entry_total    (entry_total)
    );

endmodule

[src/skt_datapath.sv]
module skt_datapath
    import skt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic [1:0]  mode,
    input  logic [63:0] key,
    input  logic [15:0] user_handle,
    input  logic [31:0] now_time,
    input  cmd_t        cmd,
    output flags_t      flags,
    output logic [1:0]  status,
    output logic [5:0]  slot,
    output logic [15:0] found_user,
    output logic [31:0] found_time,
    output logic [6:0]  entry_total
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [63:0] mem_key  [DEPTH];
    logic [15:0] mem_user [DEPTH];
    logic [31:0] mem_time [DEPTH];

    logic          ordered_reg;
    op_t           op_reg;
    logic [63:0]   key_reg;
    logic [15:0]   user_reg;
    logic [31:0]   time_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic [63:0]   rd_key_reg;
    logic [15:0]   rd_user_reg;
    logic [31:0]   rd_time_reg;
    logic [1:0]    status_reg;
    logic [5:0]    slot_reg;
    logic [15:0]   user_out_reg;
    logic [31:0]   time_out_reg;
    logic [6:0]    total_reg;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] hit_idx;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] wr_addr;
    logic          wr_en;
    logic [63:0]   wr_key;
    logic [15:0]   wr_user;
    logic [31:0]   wr_time;
    logic [CW+5:0] slot_ext;
    logic [CW+6:0] total_ext;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {1'b0, ONE_C};
    assign mid     = mid_sum[CW:1];
    assign hit_idx = flags.binary ? mid : idx_reg;

    always_comb
    begin
        flags.is_insert = (op_reg == OP_INSERT);
        flags.is_remove = (op_reg == OP_REMOVE);
        flags.is_lookup = (op_reg == OP_LOOKUP);
        flags.ordered   = ordered_reg;
        flags.binary    = ordered_reg && (op_reg != OP_INSERT);
        flags.full      = (count_reg >= DEPTH_C);
        flags.scan_end  = flags.binary ? (lo_reg >= hi_reg) : (idx_reg >= count_reg);
        flags.lt        = (rd_key_reg < key_reg);
        flags.eq        = (rd_key_reg == key_reg);
        flags.shift_end = flags.is_insert ? (sh_reg <= idx_reg) : (sh_reg >= count_reg);
    end

    always_comb
    begin
        if (cmd.shift_rd)
        begin
            rd_addr = flags.is_insert ? (sh_reg - ONE_C) : sh_reg;
        end
        else
        begin
            rd_addr = flags.binary ? mid : idx_reg;
        end
    end

    always_comb
    begin
        wr_en   = cmd.shift_wr || cmd.write_new || cmd.write_time;
        wr_addr = idx_reg;
        wr_key  = rd_key_reg;
        wr_user = rd_user_reg;
        wr_time = time_reg;
        if (cmd.shift_wr)
        begin
            wr_addr = flags.is_insert ? sh_reg : (sh_reg - ONE_C);
            wr_time = rd_time_reg;
        end
        else if (cmd.write_new)
        begin
            wr_key  = key_reg;
            wr_user = user_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd || cmd.shift_rd)
        begin
            rd_key_reg  <= mem_key[rd_addr[AW-1:0]];
            rd_user_reg <= mem_user[rd_addr[AW-1:0]];
            rd_time_reg <= mem_time[rd_addr[AW-1:0]];
        end
        if (wr_en)
        begin
            mem_key[wr_addr[AW-1:0]]  <= wr_key;
            mem_user[wr_addr[AW-1:0]] <= wr_user;
            mem_time[wr_addr[AW-1:0]] <= wr_time;
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        sh_next    = sh_reg;
        count_next = count_reg;
        if (cmd.start)
        begin
            idx_next = '0;
            lo_next  = '0;
            hi_next  = count_reg;
        end
        if (cmd.pos_end)
        begin
            idx_next = count_reg;
        end
        if (cmd.cmp)
        begin
            if (flags.binary)
            begin
                priority if (flags.eq)
                    idx_next = mid;
                else if (flags.lt)
                    lo_next = mid + ONE_C;
                else
                    hi_next = mid;
            end
            else if (flags.is_insert ? flags.lt : !flags.eq)
            begin
                idx_next = idx_reg + ONE_C;
            end
        end
        if (cmd.set_shift)
        begin
            sh_next = flags.is_insert ? count_reg : (hit_idx + ONE_C);
        end
        if (cmd.shift_wr)
        begin
            sh_next = flags.is_insert ? (sh_reg - ONE_C) : (sh_reg + ONE_C);
        end
        if (cmd.finish && (cmd.res_status == ST_OK))
        begin
            if (flags.is_insert)
                count_next = count_reg + ONE_C;
            else if (flags.is_remove)
                count_next = count_reg - ONE_C;
        end
    end

    assign slot_ext  = {6'b0, idx_reg};
    assign total_ext = {7'b0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_reg <= 1'b1;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
                ordered_reg <= cfg_write_data;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        sh_reg  <= sh_next;
        if (cmd.load)
        begin
            op_reg   <= op_t'(mode);
            key_reg  <= key;
            user_reg <= user_handle;
            time_reg <= now_time;
        end
        if (cmd.finish)
        begin
            status_reg   <= cmd.res_status;
            total_reg    <= total_ext[6:0];
            slot_reg     <= '0;
            user_out_reg <= '0;
            time_out_reg <= '0;
            if (cmd.res_status == ST_OK)
            begin
                slot_reg <= slot_ext[5:0];
                if (!flags.is_insert && !flags.is_remove)
                begin
                    user_out_reg <= rd_user_reg;
                    time_out_reg <= flags.is_lookup ? rd_time_reg : time_reg;
                end
            end
        end
    end

    assign status      = status_reg;
    assign slot        = slot_reg;
    assign found_user  = user_out_reg;
    assign found_time  = time_out_reg;
    assign entry_total = total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && cmd.res_status == ST_OK && flags.is_insert)
        |=> count_reg == $past(count_reg) + ONE_C)
        else $error("insert did not grow table");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && cmd.res_status == ST_OK && flags.is_remove)
        |=> count_reg == $past(count_reg) - ONE_C)
        else $error("remove did not shrink table");

endmodule

[src/skt_ctrl.sv]
module skt_ctrl
    import skt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    input  flags_t flags,
    output cmd_t   cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_START;
            S_START:
                priority if (flags.is_insert && flags.full)
                    state_next = S_DONE_FULL;
                else if (flags.is_insert && !flags.ordered)
                    state_next = S_WRITE;
                else
                    state_next = S_SCAN_RD;
            S_SCAN_RD:
                priority if (!flags.scan_end)
                    state_next = S_SCAN_CMP;
                else if (flags.is_insert)
                    state_next = S_WRITE;
                else
                    state_next = S_DONE_MISS;
            S_SCAN_CMP:
                priority if (flags.is_insert)
                    state_next = flags.lt ? S_SCAN_RD : S_SHIFT_RD;
                else if (!flags.eq)
                    state_next = S_SCAN_RD;
                else if (flags.is_remove)
                    state_next = S_SHIFT_RD;
                else if (flags.is_lookup)
                    state_next = S_DONE_OK;
                else
                    state_next = S_TOUCH;
            S_SHIFT_RD:
                priority if (!flags.shift_end)
                    state_next = S_SHIFT_WR;
                else if (flags.is_insert)
                    state_next = S_WRITE;
                else
                    state_next = S_DONE_OK;
            S_SHIFT_WR:
                state_next = S_SHIFT_RD;
            S_WRITE,
            S_TOUCH:
                state_next = S_DONE_OK;
            S_DONE_OK,
            S_DONE_FULL,
            S_DONE_MISS:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.res_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
                cmd.load = in_valid;
            S_START:
            begin
                cmd.start   = 1'b1;
                cmd.pos_end = flags.is_insert && !flags.ordered;
            end
            S_SCAN_RD:
                cmd.rd = !flags.scan_end;
            S_SCAN_CMP:
            begin
                cmd.cmp       = 1'b1;
                cmd.set_shift = flags.is_insert ? !flags.lt : (flags.eq && flags.is_remove);
            end
            S_SHIFT_RD:
                cmd.shift_rd = !flags.shift_end;
            S_SHIFT_WR:
                cmd.shift_wr = 1'b1;
            S_WRITE:
                cmd.write_new = 1'b1;
            S_TOUCH:
                cmd.write_time = 1'b1;
            S_DONE_OK:
                cmd.finish = out_free;
            S_DONE_FULL:
            begin
                cmd.finish     = out_free;
                cmd.res_status = ST_FULL;
            end
            S_DONE_MISS:
            begin
                cmd.finish     = out_free;
                cmd.res_status = ST_MISSING;
            end
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("result overwritten");

    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CMP) |-> $past(state_reg) == S_SCAN_RD)
        else $error("compare without read");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> $past(state_reg) == S_SHIFT_RD)
        else $error("shift write without read");

endmodule

[test/session_key_table_tb.sv]
`timescale 1ns / 1ps

module session_key_table_tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 140;
    localparam int POOL_SIZE   = 24;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [15:0] user;
        logic [31:0] stamp;
        logic [6:0]  total;
    } session_result_t;

    typedef struct {
        op_t             op;
        logic [63:0]     key;
        logic [15:0]     user;
        logic [31:0]     stamp;
        bit              typed;
        session_result_t res;
    } session_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_write_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = 2'd0;
    logic [63:0] key = 64'd0;
    logic [15:0] user_handle = 16'd0;
    logic [31:0] now_time = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] found_user;
    logic [31:0] found_time;
    logic [6:0]  entry_total;

    logic [63:0] model_keys[TABLE_DEPTH];
    logic [15:0] model_users[TABLE_DEPTH];
    logic [31:0] model_times[TABLE_DEPTH];
    int          model_count = 0;
    bit          model_sorted = 1'b1;

    session_result_t pending_results[$];
    session_row_t    directed_rows[$];
    logic [63:0]     key_pool[POOL_SIZE];
    int              mismatches = 0;
    int              idle_cycles = 0;
    bit              calm = 1'b0;

    session_key_table #(
        .DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .key           (key),
        .user_handle   (user_handle),
        .now_time      (now_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .slot          (slot),
        .found_user    (found_user),
        .found_time    (found_time),
        .entry_total   (entry_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int find_session(logic [63:0] k);
        int lo;
        int hi;
        int mid;
        if (model_sorted)
        begin
            lo = 0;
            hi = model_count - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (model_keys[mid] < k)
                    lo = mid + 1;
                else if (model_keys[mid] > k)
                    hi = mid - 1;
                else
                    return mid;
            end
            return -1;
        end
        for (int i = 0; i < model_count; i++)
            if (model_keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic session_result_t apply_session_op(op_t op, logic [63:0] k,
                                                          logic [15:0] u, logic [31:0] t);
        session_result_t r;
        int pos;
        int hit;
        r = '{ST_OK, 6'd0, 16'd0, 32'd0, 7'd0};
        if (op == OP_INSERT)
        begin
            if (model_count >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = model_count;
                if (model_sorted)
                begin
                    pos = 0;
                    while (pos < model_count && model_keys[pos] < k)
                        pos++;
                    for (int i = model_count; i > pos; i--)
                    begin
                        model_keys[i]  = model_keys[i-1];
                        model_users[i] = model_users[i-1];
                        model_times[i] = model_times[i-1];
                    end
                end
                model_keys[pos]  = k;
                model_users[pos] = u;
                model_times[pos] = t;
                model_count++;
                r.slot = pos[5:0];
            end
        end
        else
        begin
            hit = find_session(k);
            if (hit < 0)
                r.status = ST_MISSING;
            else
            begin
                r.slot = hit[5:0];
                if (op == OP_REMOVE)
                begin
                    for (int i = hit + 1; i < model_count; i++)
                    begin
                        model_keys[i-1]  = model_keys[i];
                        model_users[i-1] = model_users[i];
                        model_times[i-1] = model_times[i];
                    end
                    model_count--;
                end
                else
                begin
                    if (op == OP_TOUCH)
                        model_times[hit] = t;
                    r.user  = model_users[hit];
                    r.stamp = model_times[hit];
                end
            end
        end
        r.total = model_count[6:0];
        return r;
    endfunction

    task automatic add_row(op_t op, logic [63:0] k, logic [15:0] u, logic [31:0] t,
                           bit typed, logic [1:0] st = ST_OK, logic [5:0] sl = 0,
                           logic [15:0] fu = 0, logic [31:0] ft = 0, logic [6:0] tot = 0);
        session_row_t row;
        row.op    = op;
        row.key   = k;
        row.user  = u;
        row.stamp = t;
        row.typed = typed;
        row.res   = '{st, sl, fu, ft, tot};
        directed_rows.push_back(row);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_session_op(op_t op, logic [63:0] k, logic [15:0] u, logic [31:0] t,
                                   bit typed, session_result_t typed_res);
        session_result_t r;
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        key         <= k;
        user_handle <= u;
        now_time    <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = apply_session_op(op, k, u, t);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic settle_and_configure(bit sorted);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= sorted;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        model_sorted = sorted;
    endtask

    task automatic check_field(string name, logic [63:0] expv, logic [63:0] got);
        if (expv !== got)
        begin
            mismatches++;
            $display("%0t %s: expected %h actual %h", $time, name, expv, got);
        end
    endtask

    // result side: random stalls and compare against the oldest expectation
    always @(posedge clk)
    begin
        static int stall_left = 0;
        session_result_t e;
        logic next_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected transaction: expected none actual status %h",
                         $time, status);
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", e.status, status);
                check_field("slot", e.slot, slot);
                check_field("found_user", e.user, found_user);
                check_field("found_time", e.stamp, found_time);
                check_field("entry_total", e.total, entry_total);
            end
        end
        next_ready = 1'b1;
        if (stall_left > 0)
        begin
            stall_left--;
            next_ready = 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 30)
        begin
            next_ready = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 2);
        end
        out_ready <= next_ready;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int r;
        int insert_pct[PHASES] = '{75, 75, 40, 20, 60, 30, 80, 25};
        bit phase_sorted[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        logic [63:0] k;
        session_row_t row;
        op_t op;

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        add_row(OP_LOOKUP, 64'd5, 16'd1, 32'd1, 1'b1, ST_MISSING, 0, 0, 0, 0);
        add_row(OP_REMOVE, 64'd5, 16'd1, 32'd1, 1'b1, ST_MISSING, 0, 0, 0, 0);
        add_row(OP_TOUCH, 64'd5, 16'd1, 32'd1, 1'b1, ST_MISSING, 0, 0, 0, 0);
        add_row(OP_INSERT, '1, '1, '1, 1'b1, ST_OK, 0, 0, 0, 1);
        add_row(OP_INSERT, 64'd0, 16'd0, 32'd0, 1'b1, ST_OK, 0, 0, 0, 2);
        add_row(OP_LOOKUP, '1, 16'd3, 32'd3, 1'b1, ST_OK, 1, 16'hffff, 32'hffffffff, 2);
        add_row(OP_LOOKUP, 64'd0, 16'd3, 32'd3, 1'b1, ST_OK, 0, 0, 0, 2);
        add_row(OP_INSERT, 64'd1000, 16'h1234, 32'd5, 1'b0);
        add_row(OP_INSERT, 64'd1000, 16'd7, 32'd6, 1'b0);
        add_row(OP_LOOKUP, 64'd1000, 16'd0, 32'd0, 1'b0);
        add_row(OP_TOUCH, 64'd1000, 16'd0, 32'd99, 1'b0);
        add_row(OP_TOUCH, '1, 16'd0, 32'h12345678, 1'b0);
        add_row(OP_REMOVE, 64'd0, 16'd0, 32'd0, 1'b1, ST_OK, 0, 0, 0, 3);
        add_row(OP_REMOVE, '1, 16'd0, 32'd0, 1'b0);
        add_row(OP_LOOKUP, 64'd77, 16'd0, 32'd0, 1'b0);
        add_row(OP_REMOVE, 64'd1000, 16'd0, 32'd0, 1'b0);
        add_row(OP_REMOVE, 64'd1000, 16'd0, 32'd0, 1'b0);
        add_row(OP_REMOVE, 64'd1000, 16'd0, 32'd0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        settle_and_configure(1'b1);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_session_op(row.op, row.key, row.user, row.stamp, row.typed, row.res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle_and_configure(phase_sorted[p]);
            calm = (p == 2 || p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < insert_pct[p])
                    op = OP_INSERT;
                else
                    op = op_t'($urandom_range(1, 3));
                r = $urandom_range(0, 99);
                if (r < 70)
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (r < 80)
                    k = (r < 75) ? 64'd0 : '1;
                else
                    k = {$urandom, $urandom};
                send_session_op(op, k, 16'($urandom), $urandom, 1'b0, row.res);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
